/* src/tffl_pkg.sv */
// Shared types, character codes and lookup functions for the two-fan, four-light decoder.
// No dependencies; imported by every module of the block.
`default_nettype none
package tffl_pkg;

	localparam int TFFL_QUEUE_DEPTH = 2;

	localparam logic [2:0] CMD_NONE     = 3'd0;
	localparam logic [2:0] CMD_PING     = 3'd1;
	localparam logic [2:0] CMD_LIGHT    = 3'd2;
	localparam logic [2:0] CMD_FAN_ON   = 3'd3;
	localparam logic [2:0] CMD_FAN_OFF  = 3'd4;
	localparam logic [2:0] CMD_FAN_UP   = 3'd5;
	localparam logic [2:0] CMD_FAN_DOWN = 3'd6;

	localparam logic [7:0] CH_P = "P";
	localparam logic [7:0] CH_L = "L";
	localparam logic [7:0] CH_F = "F";
	localparam logic [7:0] CH_U = "U";
	localparam logic [7:0] CH_D = "D";
	localparam logic [7:0] CH_0 = "0";
	localparam logic [7:0] CH_1 = "1";
	localparam logic [7:0] CH_2 = "2";
	localparam logic [7:0] CH_3 = "3";
	localparam logic [7:0] CH_4 = "4";
	localparam logic [7:0] CH_Q = "Q";
	localparam logic [7:0] CH_B = "B";
	localparam logic [7:0] CH_W = "W";

	localparam logic [2:0] LEVEL_MAX = 3'd5;

	typedef struct packed {
		logic [2:0] kind;
		logic [1:0] arg;
	} tffl_cmd_t;

	typedef struct packed {
		logic [2:0] level;
		logic [2:0] memory;
		logic [7:0] ack;
	} tffl_fan_res_t;

	function automatic logic [7:0] light_ack(input logic [1:0] idx);
		logic [7:0] c;
		unique case (idx)
			2'd0: c = "S";
			2'd1: c = "P";
			2'd2: c = "R";
			default: c = "G";
		endcase
		return c;
	endfunction

	function automatic logic [7:0] level_ack(input logic fan, input logic [2:0] lv);
		logic [7:0] c;
		unique case (lv)
			3'd0: c = 8'd0;
			3'd1: c = fan ? "K" : "A";
			3'd2: c = fan ? "Z" : "C";
			3'd3: c = fan ? "X" : "D";
			3'd4: c = fan ? "I" : "E";
			default: c = fan ? "J" : "F";
		endcase
		return c;
	endfunction

	function automatic logic [4:0] fan_leds(input logic [2:0] lv);
		logic [4:0] v;
		unique case (lv)
			3'd0: v = 5'b00000;
			3'd1: v = 5'b00001;
			3'd2: v = 5'b00011;
			3'd3: v = 5'b00111;
			3'd4: v = 5'b01111;
			default: v = 5'b11111;
		endcase
		return v;
	endfunction

	function automatic logic [3:0] fan_relays(input logic [2:0] lv);
		logic [3:0] v;
		unique case (lv)
			3'd0: v = 4'b0000;
			3'd1: v = 4'b0010;
			3'd2: v = 4'b0001;
			3'd3: v = 4'b0101;
			3'd4: v = 4'b0011;
			default: v = 4'b1000;
		endcase
		return v;
	endfunction

	function automatic tffl_fan_res_t fan_exec(input logic [2:0] kind, input logic fan,
		input logic [2:0] lv, input logic [2:0] mem);
		tffl_fan_res_t r;
		r.level  = lv;
		r.memory = mem;
		r.ack    = 8'd0;
		unique case (kind)
			CMD_FAN_ON: begin
				if (mem >= 3'd1 && mem <= LEVEL_MAX) begin
					r.level = mem;
					r.ack   = level_ack(fan, mem);
				end else begin
					r.level = 3'd1;
				end
			end
			CMD_FAN_OFF: begin
				r.level = 3'd0;
				r.ack   = fan ? CH_W : CH_B;
			end
			CMD_FAN_UP: begin
				if (lv < LEVEL_MAX) begin
					r.level  = lv + 3'd1;
					r.memory = lv + 3'd1;
					r.ack    = level_ack(fan, 3'(lv + 3'd1));
				end
			end
			CMD_FAN_DOWN: begin
				if (lv >= 3'd2 && lv <= LEVEL_MAX) begin
					r.level  = lv - 3'd1;
					r.memory = lv - 3'd1;
					r.ack    = level_ack(fan, 3'(lv - 3'd1));
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

/* src/tffl_front.sv */
// Front end: pairs received bytes and classifies each pair into a command.
// Depends on tffl_pkg.
`default_nettype none
module tffl_front
	import tffl_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	input  wire logic [7:0] rx_byte,
	input  wire logic      q_full,
	output logic           in_ready,
	output logic           push,
	output tffl_cmd_t      push_cmd
);

	logic [7:0] first_q;
	logic       have_q;
	tffl_cmd_t  pair_cmd;

	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;

	always_comb begin
		pair_cmd.kind = CMD_NONE;
		pair_cmd.arg  = 2'd0;
		priority if (first_q == CH_P && rx_byte == CH_1) begin
			pair_cmd.kind = CMD_PING;
		end else if (first_q == CH_L && rx_byte >= CH_1 && rx_byte <= CH_4) begin
			pair_cmd.kind = CMD_LIGHT;
			pair_cmd.arg  = 2'(rx_byte[1:0] - 2'd1);
		end else if (first_q == CH_F && rx_byte >= CH_0 && rx_byte <= CH_3) begin
			pair_cmd.kind = rx_byte[0] ? CMD_FAN_OFF : CMD_FAN_ON;
			pair_cmd.arg  = {1'b0, rx_byte[1]};
		end else if ((first_q == CH_U || first_q == CH_D) &&
			(rx_byte == CH_1 || rx_byte == CH_2)) begin
			pair_cmd.kind = (first_q == CH_U) ? CMD_FAN_UP : CMD_FAN_DOWN;
			pair_cmd.arg  = {1'b0, rx_byte[1]};
		end
	end

	always_comb begin
		if (have_q) begin
			push_cmd = pair_cmd;
		end else begin
			push_cmd.kind = CMD_NONE;
			push_cmd.arg  = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 8'd0;
			have_q  <= 1'b0;
		end else if (push) begin
			if (!have_q) begin
				first_q <= rx_byte;
			end
			have_q <= !have_q;
		end
	end

endmodule
`default_nettype wire

/* src/tffl_queue.sv */
// Short command queue between the front end and the back end.
// Depends on tffl_pkg for the command type.
`default_nettype none
module tffl_queue
	import tffl_pkg::*;
#(
	parameter int DEPTH = TFFL_QUEUE_DEPTH
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  tffl_cmd_t push_cmd,
	input  wire logic pop,
	output tffl_cmd_t pop_cmd,
	output logic      full,
	output logic      empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	tffl_cmd_t       mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign pop_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + AW'(1);
			end
			unique case ({push, pop})
				2'b10: count_q <= count_q + CW'(1);
				2'b01: count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("push into a full command queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("pop from an empty command queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("command queue count out of range");

endmodule
`default_nettype wire

/* src/tffl_back.sv */
// Back end: executes queued commands on the light and fan state and holds the result register.
// Depends on tffl_pkg.
`default_nettype none
module tffl_back
	import tffl_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       q_empty,
	input  tffl_cmd_t       cmd,
	output logic            pop,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            ack_valid,
	output logic [7:0]      ack_char,
	output logic [3:0]      light_drive,
	output logic [4:0]      fan1_leds,
	output logic [3:0]      fan1_relays,
	output logic [4:0]      fan2_leds,
	output logic [3:0]      fan2_relays
);

	logic [3:0]    light_q;
	logic [2:0]    lv_q  [2];
	logic [2:0]    mem_q [2];
	logic          out_valid_q;
	logic [7:0]    ack_q;
	logic [3:0]    light_out_q;
	logic [2:0]    lv_out_q [2];

	logic [3:0]    light_nx;
	logic [2:0]    lv_nx  [2];
	logic [2:0]    mem_nx [2];
	logic [7:0]    ack_nx;
	tffl_fan_res_t fan_res;

	assign pop = !q_empty && (!out_valid_q || out_ready);

	always_comb begin
		light_nx  = light_q;
		lv_nx[0]  = lv_q[0];
		lv_nx[1]  = lv_q[1];
		mem_nx[0] = mem_q[0];
		mem_nx[1] = mem_q[1];
		ack_nx    = 8'd0;
		fan_res   = fan_exec(cmd.kind, cmd.arg[0], lv_q[cmd.arg[0]], mem_q[cmd.arg[0]]);
		unique case (cmd.kind)
			CMD_PING: begin
				ack_nx = CH_Q;
			end
			CMD_LIGHT: begin
				light_nx = light_q ^ (4'b0001 << cmd.arg);
				ack_nx   = light_ack(cmd.arg);
			end
			CMD_FAN_ON, CMD_FAN_OFF, CMD_FAN_UP, CMD_FAN_DOWN: begin
				lv_nx[cmd.arg[0]]  = fan_res.level;
				mem_nx[cmd.arg[0]] = fan_res.memory;
				ack_nx             = fan_res.ack;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light_q     <= 4'd0;
			lv_q[0]     <= 3'd0;
			lv_q[1]     <= 3'd0;
			mem_q[0]    <= 3'd0;
			mem_q[1]    <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				light_q     <= light_nx;
				lv_q[0]     <= lv_nx[0];
				lv_q[1]     <= lv_nx[1];
				mem_q[0]    <= mem_nx[0];
				mem_q[1]    <= mem_nx[1];
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ack_q       <= ack_nx;
			light_out_q <= light_nx;
			lv_out_q[0] <= lv_nx[0];
			lv_out_q[1] <= lv_nx[1];
		end
	end

	assign out_valid   = out_valid_q;
	assign ack_valid   = (ack_q != 8'd0);
	assign ack_char    = ack_q;
	assign light_drive = light_out_q;
	assign fan1_leds   = fan_leds(lv_out_q[0]);
	assign fan1_relays = fan_relays(lv_out_q[0]);
	assign fan2_leds   = fan_leds(lv_out_q[1]);
	assign fan2_relays = fan_relays(lv_out_q[1]);

	a_pop_presents: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> out_valid_q)
		else $error("executed command did not produce a result");

	a_result_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (light_out_q == light_q && lv_out_q[0] == lv_q[0] &&
			lv_out_q[1] == lv_q[1]))
		else $error("result register disagrees with the executed state");

endmodule
`default_nettype wire

/* src/two_fan_four_light_command_decoder_core.sv */
// Top level of the two-fan, four-light command decoder.
// Depends on tffl_pkg, tffl_front, tffl_queue and tffl_back.
//
// Channel  Direction  Handshake              Payload
// input    in         in_valid / in_ready    rx_byte
// result   out        out_valid / out_ready  ack_valid, ack_char, light_drive,
//                                            fan1_leds, fan1_relays, fan2_leds, fan2_relays
//
// One byte is accepted per cycle when the result side keeps up; every byte gives one result.
// A result is registered twice after its byte is accepted: first in the command queue,
// then in the result register in the back end.
// The queue holds QUEUE_DEPTH commands, so input keeps being accepted during an output stall
// until it fills.
// Reset clears the pairing state, lights, fan levels and remembered speeds at once.
`default_nettype none
module two_fan_four_light_command_decoder_core
	import tffl_pkg::*;
#(
	parameter int QUEUE_DEPTH = TFFL_QUEUE_DEPTH
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] rx_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            ack_valid,
	output logic [7:0]      ack_char,
	output logic [3:0]      light_drive,
	output logic [4:0]      fan1_leds,
	output logic [3:0]      fan1_relays,
	output logic [4:0]      fan2_leds,
	output logic [3:0]      fan2_relays
);

	logic      push;
	logic      pop;
	logic      q_full;
	logic      q_empty;
	tffl_cmd_t push_cmd;
	tffl_cmd_t pop_cmd;

	tffl_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.rx_byte  (rx_byte),
		.q_full   (q_full),
		.in_ready (in_ready),
		.push     (push),
		.push_cmd (push_cmd)
	);

	tffl_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.full     (q_full),
		.empty    (q_empty)
	);

	tffl_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.cmd         (pop_cmd),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.ack_valid   (ack_valid),
		.ack_char    (ack_char),
		.light_drive (light_drive),
		.fan1_leds   (fan1_leds),
		.fan1_relays (fan1_relays),
		.fan2_leds   (fan2_leds),
		.fan2_relays (fan2_relays)
	);

endmodule
`default_nettype wire

/* verif/tffl_status_check.sv */
// Checker for the two-fan, four-light command decoder: watches both channels, predicts every
// result from the accepted bytes and compares it field by field in order of arrival.
// Depends on tffl_pkg for the command codes and character constants.
module tffl_status_check
	import tffl_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic       in_ready,
	input  wire logic [7:0] rx_byte,
	input  wire logic       out_valid,
	input  wire logic       out_ready,
	input  wire logic       ack_valid,
	input  wire logic [7:0] ack_char,
	input  wire logic [3:0] light_drive,
	input  wire logic [4:0] fan1_leds,
	input  wire logic [3:0] fan1_relays,
	input  wire logic [4:0] fan2_leds,
	input  wire logic [3:0] fan2_relays,
	output int              fail_count,
	output int              results_due
);

	typedef struct packed {
		logic       ack_valid;
		logic [7:0] ack_char;
		logic [3:0] lights;
		logic [4:0] f1_leds;
		logic [3:0] f1_relays;
		logic [4:0] f2_leds;
		logic [3:0] f2_relays;
	} status_t;

	localparam logic [39:0] FAN1_CHARS  = "FEDCA";
	localparam logic [39:0] FAN2_CHARS  = "JIXZK";
	localparam logic [31:0] LIGHT_CHARS = "GRPS";
	localparam logic [23:0] RELAY_MAP   = {4'h8, 4'h3, 4'h5, 4'h1, 4'h2, 4'h0};

	status_t    expected_status[$];
	logic       pair_open;
	logic [7:0] pair_first;
	logic [3:0] lights;
	logic [2:0] fan_lvl [2];
	logic [2:0] fan_mem [2];
	int         mismatches = 0;
	int         results_seen = 0;

	function automatic logic [7:0] speed_char(input int f, input logic [2:0] lv);
		logic [39:0] chars;
		chars = f ? FAN2_CHARS : FAN1_CHARS;
		return chars[8 * (lv - 3'd1) +: 8];
	endfunction

	task automatic fan_step(input logic [2:0] op, input int f, output logic [7:0] ack);
		ack = 8'd0;
		case (op)
			CMD_FAN_ON: begin
				if (fan_mem[f] >= 3'd1 && fan_mem[f] <= LEVEL_MAX) begin
					fan_lvl[f] = fan_mem[f];
					ack = speed_char(f, fan_mem[f]);
				end else begin
					fan_lvl[f] = 3'd1;
				end
			end
			CMD_FAN_OFF: begin
				fan_lvl[f] = 3'd0;
				ack = f ? CH_W : CH_B;
			end
			CMD_FAN_UP: begin
				if (fan_lvl[f] < LEVEL_MAX) begin
					fan_lvl[f] = fan_lvl[f] + 3'd1;
					fan_mem[f] = fan_lvl[f];
					ack = speed_char(f, fan_lvl[f]);
				end
			end
			CMD_FAN_DOWN: begin
				if (fan_lvl[f] >= 3'd2 && fan_lvl[f] <= LEVEL_MAX) begin
					fan_lvl[f] = fan_lvl[f] - 3'd1;
					fan_mem[f] = fan_lvl[f];
					ack = speed_char(f, fan_lvl[f]);
				end
			end
			default: begin
			end
		endcase
	endtask

	task automatic decode_pair(input logic [7:0] a, input logic [7:0] b, output logic [7:0] ack);
		logic [1:0] idx;
		ack = 8'd0;
		if (a == CH_P && b == CH_1) begin
			ack = CH_Q;
		end else if (a == CH_L && b >= CH_1 && b <= CH_4) begin
			idx = b[1:0] - 2'd1;
			lights[idx] = ~lights[idx];
			ack = LIGHT_CHARS[8 * idx +: 8];
		end else if (a == CH_F && b >= CH_0 && b <= CH_3) begin
			fan_step(b[0] ? CMD_FAN_OFF : CMD_FAN_ON, b[1], ack);
		end else if ((a == CH_U || a == CH_D) && (b == CH_1 || b == CH_2)) begin
			fan_step(a == CH_U ? CMD_FAN_UP : CMD_FAN_DOWN, b == CH_2, ack);
		end
	endtask

	task automatic predict_byte(input logic [7:0] b);
		logic [7:0] ack;
		status_t s;
		ack = 8'd0;
		if (!pair_open) begin
			pair_first = b;
			pair_open = 1'b1;
		end else begin
			pair_open = 1'b0;
			decode_pair(pair_first, b, ack);
		end
		s.ack_valid = (ack != 8'd0);
		s.ack_char  = ack;
		s.lights    = lights;
		s.f1_leds   = (5'd1 << fan_lvl[0]) - 5'd1;
		s.f1_relays = RELAY_MAP[4 * fan_lvl[0] +: 4];
		s.f2_leds   = (5'd1 << fan_lvl[1]) - 5'd1;
		s.f2_relays = RELAY_MAP[4 * fan_lvl[1] +: 4];
		expected_status.push_back(s);
	endtask

	task automatic report_mismatch(input string msg);
		$display("mismatch: %s", msg);
		mismatches++;
	endtask

	task automatic compare_field(input string name, input logic [7:0] got, input logic [7:0] want);
		if (got !== want)
			report_mismatch($sformatf("result %0d %s is %0h, predicted %0h",
				results_seen, name, got, want));
	endtask

	task automatic compare_result(input status_t got);
		status_t want;
		if (expected_status.size() == 0) begin
			report_mismatch($sformatf("result %0d arrived with no transaction outstanding",
				results_seen));
		end else begin
			want = expected_status.pop_front();
			compare_field("ack_valid", 8'(got.ack_valid), 8'(want.ack_valid));
			compare_field("ack_char", got.ack_char, want.ack_char);
			compare_field("light_drive", 8'(got.lights), 8'(want.lights));
			compare_field("fan1_leds", 8'(got.f1_leds), 8'(want.f1_leds));
			compare_field("fan1_relays", 8'(got.f1_relays), 8'(want.f1_relays));
			compare_field("fan2_leds", 8'(got.f2_leds), 8'(want.f2_leds));
			compare_field("fan2_relays", 8'(got.f2_relays), 8'(want.f2_relays));
		end
		results_seen++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_open  = 1'b0;
			pair_first = 8'd0;
			lights     = 4'd0;
			fan_lvl[0] = 3'd0;
			fan_lvl[1] = 3'd0;
			fan_mem[0] = 3'd0;
			fan_mem[1] = 3'd0;
			expected_status.delete();
			fail_count  <= mismatches;
			results_due <= 0;
		end else begin
			if (in_valid && in_ready)
				predict_byte(rx_byte);
			if (out_valid && out_ready)
				compare_result({ack_valid, ack_char, light_drive, fan1_leds, fan1_relays,
					fan2_leds, fan2_relays});
			fail_count  <= mismatches;
			results_due <= expected_status.size();
		end
	end

endmodule

/* verif/two_fan_four_light_command_decoder_core_tb.sv */
// Testbench top for the two-fan, four-light command decoder: drives directed and random
// command bytes with random idling on both channels and gives the verdict.
// Depends on tffl_pkg, the decoder core and the tffl_status_check checker.
module two_fan_four_light_command_decoder_core_tb;
	import tffl_pkg::*;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] rx_byte = 8'd0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       ack_valid;
	logic [7:0] ack_char;
	logic [3:0] light_drive;
	logic [4:0] fan1_leds;
	logic [3:0] fan1_relays;
	logic [4:0] fan2_leds;
	logic [3:0] fan2_relays;
	int         fail_count;
	int         results_due;
	logic       tx_burst = 1'b0;
	logic       rx_burst = 1'b0;
	int         bytes_sent = 0;

	two_fan_four_light_command_decoder_core i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.rx_byte     (rx_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.ack_valid   (ack_valid),
		.ack_char    (ack_char),
		.light_drive (light_drive),
		.fan1_leds   (fan1_leds),
		.fan1_relays (fan1_relays),
		.fan2_leds   (fan2_leds),
		.fan2_relays (fan2_relays)
	);

	tffl_status_check i_status_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.rx_byte     (rx_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.ack_valid   (ack_valid),
		.ack_char    (ack_char),
		.light_drive (light_drive),
		.fan1_leds   (fan1_leds),
		.fan1_relays (fan1_relays),
		.fan2_leds   (fan2_leds),
		.fan2_relays (fan2_relays),
		.fail_count  (fail_count),
		.results_due (results_due)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic send_byte(input logic [7:0] b);
		int gap;
		if ($urandom_range(0, 39) == 0)
			tx_burst = !tx_burst;
		gap = tx_burst ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			in_valid <= 1'b0;
			rx_byte  <= 8'($urandom_range(0, 255));
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (!(in_valid && in_ready));
		bytes_sent++;
	endtask

	task automatic send_pair(input logic [7:0] a, input logic [7:0] b);
		send_byte(a);
		send_byte(b);
	endtask

	task automatic send_random_pair();
		int    pick;
		int    kind;
		string heads;
		heads = "PLFUD";
		pick = $urandom_range(0, 99);
		if (pick < 85) begin
			kind = $urandom_range(0, 9);
			if (kind == 0)
				send_pair(CH_P, CH_1);
			else if (kind == 1)
				send_pair(CH_L, 8'(CH_1 + $urandom_range(0, 3)));
			else if (kind <= 3)
				send_pair(CH_F, 8'(CH_0 + $urandom_range(0, 3)));
			else if (kind <= 7)
				send_pair(CH_U, 8'(CH_1 + $urandom_range(0, 1)));
			else
				send_pair(CH_D, 8'(CH_1 + $urandom_range(0, 1)));
		end else if (pick < 93) begin
			send_pair(heads[$urandom_range(0, 4)], 8'(CH_0 - 8'd1 + $urandom_range(0, 6)));
		end else begin
			send_pair(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 39) == 0)
				rx_burst = !rx_burst;
			stall = rx_burst ? 0 : $urandom_range(0, 11);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	initial begin
		string directed;
		directed = "P1L1L4F0D1U1F1D1F0F2U2F3";
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < directed.len(); i++)
			send_byte(directed[i]);
		send_pair(8'h00, 8'hFF);
		while (bytes_sent < 650)
			send_random_pair();
		in_valid <= 1'b0;
		do @(posedge clk); while (results_due != 0);
		repeat (10) @(posedge clk);
		if (fail_count == 0 && results_due == 0)
			$display("** two_fan_four_light_command_decoder_core: PASSED **");
		else
			$display("** two_fan_four_light_command_decoder_core: FAILED **");
		$finish;
	end

	initial begin
		#3000000;
		$display("** two_fan_four_light_command_decoder_core: FAILED **");
		$finish;
	end

endmodule
